/* hw/rtl/bfsp_pkg.sv */
// Shared types and constants for the Bellman-Ford shortest-path core.
// Request and result payload structs, command codes, register map.
// No dependencies.
`timescale 1ns / 1ps

package bfsp_pkg;

    // Default sizing, handed to the top level as parameter defaults
    localparam int MAX_NODES_DEF   = 32;
    localparam int MAX_EDGES_DEF   = 256;
    localparam int WEIGHT_BITS_DEF = 16;

    // Fixed payload widths
    localparam int KIND_W   = 2;
    localparam int NODE_W   = 5;
    localparam int WFIELD_W = 16;
    localparam int COST_W   = 24;
    localparam int CFG_W    = 6;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_NODES_USED = 1'b0;
    localparam logic [CFG_W-1:0] NODES_USED_RST = 6'd1;

    // Command codes
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ADD   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_RUN   = 2'd2;

    // Output saturation bounds
    localparam int COST_MAX = 8388607;
    localparam int COST_MIN = -8388608;

    typedef struct packed {
        logic [KIND_W-1:0]          kind;
        logic [NODE_W-1:0]          edge_source;
        logic [NODE_W-1:0]          edge_target;
        logic signed [WFIELD_W-1:0] edge_weight;
    } request_t;

    typedef struct packed {
        logic [NODE_W-1:0]        node_id;
        logic signed [COST_W-1:0] path_cost;
        logic                     reachable;
        logic                     negative_cycle;
        logic                     edges_dropped;
        logic                     last;
    } result_t;

    // Sequencer controls for the relaxation unit
    typedef struct packed {
        logic init;        // start of run: clear marks, seed node 0
        logic edge_valid;  // edge data from the edge store is live
        logic edge_check;  // this edge belongs to the cycle-check pass
        logic report;      // port A reads out distances
    } relax_ctrl_t;

endpackage

/* hw/rtl/bfsp_edge_store.sv */
// Edge store: one synchronous memory of source, target and weight,
// fill count and overflow flag. Depends on bfsp_pkg.
`timescale 1ns / 1ps

module bfsp_edge_store #(
    parameter int MAX_EDGES   = bfsp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
    parameter int EDGE_IDX_W  = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1,
    parameter int EDGE_CNT_W  = $clog2(MAX_EDGES + 1)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  bfsp_pkg::request_t            request,
    input  logic [EDGE_IDX_W-1:0]         rd_addr,
    output logic [bfsp_pkg::NODE_W-1:0]   rd_source,
    output logic [bfsp_pkg::NODE_W-1:0]   rd_target,
    output logic signed [WEIGHT_BITS-1:0] rd_weight,
    output logic [EDGE_CNT_W-1:0]         edge_total,
    output logic                          overflow
);

    localparam int ENTRY_W = 2 * bfsp_pkg::NODE_W + WEIGHT_BITS;

    logic [ENTRY_W-1:0]    edge_mem [MAX_EDGES];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic [EDGE_CNT_W-1:0] total_reg;
    logic [EDGE_CNT_W-1:0] total_next;
    logic                  overflow_reg;
    logic                  overflow_next;
    logic                  wr_en;
    logic [31:0]           weight_ext;
    logic [ENTRY_W-1:0]    wr_data;

    // Sign-extend the weight field, then wrap to the stored width
    assign weight_ext = {{(32 - bfsp_pkg::WFIELD_W){request.edge_weight[bfsp_pkg::WFIELD_W-1]}},
                         request.edge_weight};
    assign wr_data = {request.edge_source, request.edge_target, weight_ext[WEIGHT_BITS-1:0]};

    // Count and overflow update
    always_comb
    begin
        total_next    = total_reg;
        overflow_next = overflow_reg;
        wr_en         = 1'b0;
        if (accept)
        begin
            case (request.kind)
                bfsp_pkg::KIND_CLEAR:
                begin
                    total_next    = '0;
                    overflow_next = 1'b0;
                end
                bfsp_pkg::KIND_ADD:
                begin
                    if (int'(total_reg) >= MAX_EDGES)
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        wr_en      = 1'b1;
                        total_next = EDGE_CNT_W'(total_reg + 1'b1);
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg    <= '0;
            overflow_reg <= 1'b0;
        end
        else
        begin
            total_reg    <= total_next;
            overflow_reg <= overflow_next;
        end
    end

    // Write at the fill count, registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            edge_mem[total_reg[EDGE_IDX_W-1:0]] <= wr_data;
        end
        rd_data_reg <= edge_mem[rd_addr];
    end

    assign rd_source  = rd_data_reg[ENTRY_W-1 -: bfsp_pkg::NODE_W];
    assign rd_target  = rd_data_reg[WEIGHT_BITS +: bfsp_pkg::NODE_W];
    assign rd_weight  = $signed(rd_data_reg[WEIGHT_BITS-1:0]);
    assign edge_total = total_reg;
    assign overflow   = overflow_reg;

endmodule

/* hw/rtl/bfsp_relax_unit.sv */
// Relaxation unit: distance memory with two read ports, reached marks,
// one-edge-per-cycle read-modify-write with write forwarding, cycle flag.
// Depends on bfsp_pkg.
`timescale 1ns / 1ps

module bfsp_relax_unit #(
    parameter int MAX_NODES   = bfsp_pkg::MAX_NODES_DEF,
    parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF,
    parameter int NODE_IDX_W  = $clog2(MAX_NODES),
    parameter int NODE_CNT_W  = $clog2(MAX_NODES + 1),
    parameter int DIST_W      = 30
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  bfsp_pkg::relax_ctrl_t         ctrl,
    input  logic [NODE_CNT_W-1:0]         node_limit,
    input  logic [bfsp_pkg::NODE_W-1:0]   edge_source,
    input  logic [bfsp_pkg::NODE_W-1:0]   edge_target,
    input  logic signed [WEIGHT_BITS-1:0] edge_weight,
    input  logic [NODE_IDX_W-1:0]         report_addr,
    output logic signed [DIST_W-1:0]      report_dist,
    output logic                          report_reached,
    output logic                          neg_found
);

    logic signed [DIST_W-1:0] dist_mem [MAX_NODES];
    logic signed [DIST_W-1:0] rd_a_reg;
    logic signed [DIST_W-1:0] rd_b_reg;
    logic [NODE_IDX_W-1:0]    rd_a_addr;
    logic [NODE_IDX_W-1:0]    rd_b_addr;
    logic [MAX_NODES-1:0]     reached_reg;
    logic                     rpt_reached_reg;

    // Stage C: edge whose distances are being read out
    logic                          c_valid_reg;
    logic                          c_check_reg;
    logic [bfsp_pkg::NODE_W-1:0]   c_src_reg;
    logic [bfsp_pkg::NODE_W-1:0]   c_tgt_reg;
    logic signed [WEIGHT_BITS-1:0] c_weight_reg;

    // Last write, forwarded to the edge right behind it
    logic                     fwd_valid_reg;
    logic [NODE_IDX_W-1:0]    fwd_addr_reg;
    logic signed [DIST_W-1:0] fwd_data_reg;

    logic                     neg_reg;
    logic [NODE_IDX_W-1:0]    c_src_idx;
    logic [NODE_IDX_W-1:0]    c_tgt_idx;
    logic                     in_range;
    logic signed [DIST_W-1:0] dist_s;
    logic signed [DIST_W-1:0] dist_t;
    logic signed [DIST_W-1:0] cand;
    logic                     improve;
    logic                     wr_en;
    logic [NODE_IDX_W-1:0]    wr_addr;
    logic signed [DIST_W-1:0] wr_data;

    // Read addresses: report readout or the edge now in stage B
    assign rd_a_addr = ctrl.report ? report_addr : NODE_IDX_W'(edge_source);
    assign rd_b_addr = NODE_IDX_W'(edge_target);

    // Compare and update for the edge in stage C
    assign c_src_idx = NODE_IDX_W'(c_src_reg);
    assign c_tgt_idx = NODE_IDX_W'(c_tgt_reg);
    assign in_range  = (int'(c_src_reg) < int'(node_limit)) && (int'(c_tgt_reg) < int'(node_limit));
    assign dist_s = (fwd_valid_reg && fwd_addr_reg == c_src_idx) ? fwd_data_reg : rd_a_reg;
    assign dist_t = (fwd_valid_reg && fwd_addr_reg == c_tgt_idx) ? fwd_data_reg : rd_b_reg;
    assign cand   = dist_s + DIST_W'(c_weight_reg);
    assign improve = c_valid_reg && in_range && reached_reg[c_src_idx] &&
                     (!reached_reg[c_tgt_idx] || cand < dist_t);

    // Write port: seed node 0 at run start, else relaxation result
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = c_tgt_idx;
        wr_data = cand;
        if (ctrl.init)
        begin
            wr_en   = 1'b1;
            wr_addr = '0;
            wr_data = '0;
        end
        else if (improve && !c_check_reg)
        begin
            wr_en = 1'b1;
        end
    end

    // Distance memory, read before write
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            dist_mem[wr_addr] <= wr_data;
        end
        rd_a_reg <= dist_mem[rd_a_addr];
        rd_b_reg <= dist_mem[rd_b_addr];
    end

    // Reached marks and stage payload
    always_ff @(posedge clk)
    begin
        if (ctrl.init)
        begin
            reached_reg <= MAX_NODES'(1);
        end
        else if (wr_en)
        begin
            reached_reg[wr_addr] <= 1'b1;
        end
        rpt_reached_reg <= reached_reg[rd_a_addr];
        c_check_reg     <= ctrl.edge_check;
        c_src_reg       <= edge_source;
        c_tgt_reg       <= edge_target;
        c_weight_reg    <= edge_weight;
        fwd_addr_reg    <= wr_addr;
        fwd_data_reg    <= wr_data;
    end

    // Stage valid, forward valid and cycle flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            fwd_valid_reg <= 1'b0;
            neg_reg       <= 1'b0;
        end
        else
        begin
            c_valid_reg   <= ctrl.edge_valid;
            fwd_valid_reg <= wr_en;
            if (ctrl.init)
            begin
                neg_reg <= 1'b0;
            end
            else if (improve && c_check_reg)
            begin
                neg_reg <= 1'b1;
            end
        end
    end

    assign report_dist    = rd_a_reg;
    assign report_reached = rpt_reached_reg;
    assign neg_found      = neg_reg;

endmodule

/* hw/rtl/bellman_ford_shortest_path_core.sv */
// Bellman-Ford single-source shortest-path core: top level with the
// configuration port and the run sequencer. Depends on bfsp_pkg,
// bfsp_edge_store and bfsp_relax_unit.
//
// Usage: requests enter on request when start is high and busy is low.
// A clear or add request gives no result; busy stays low. A run request
// raises busy, relaxes every stored edge once per pass for n-1 passes plus
// one cycle-check pass, one edge per cycle through the distance memory's
// read-modify-write loop, then streams results on result with result_valid
// high for one cycle each: either n node results in node order or one
// negative-cycle result (n nodes in use). Results cannot be held off. The
// node-count register is written through the APB port; the user must
// write it only while idle, as the block does not enforce this. Reset
// empties the edge store, clears the overflow flag and sets the node count
// to 1; no clearing pass is needed.
`timescale 1ns / 1ps

module bellman_ford_shortest_path_core #(
    parameter int MAX_NODES   = bfsp_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = bfsp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = bfsp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  bfsp_pkg::request_t                request,
    output logic                              result_valid,
    output bfsp_pkg::result_t                 result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [bfsp_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [bfsp_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [bfsp_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);

    localparam int EDGE_IDX_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int EDGE_CNT_W = $clog2(MAX_EDGES + 1);
    localparam int NODE_IDX_W = $clog2(MAX_NODES);
    localparam int NODE_CNT_W = $clog2(MAX_NODES + 1);
    localparam int DIST_SUM_W = WEIGHT_BITS + EDGE_IDX_W + NODE_IDX_W + 2;
    localparam int DIST_W     = (DIST_SUM_W > bfsp_pkg::COST_W) ? DIST_SUM_W : bfsp_pkg::COST_W;
    localparam logic [1:0] DRAIN_LAST = 2'd2;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_RELAX  = 5'b00010,
        ST_DRAIN  = 5'b00100,
        ST_REPORT = 5'b01000,
        ST_FLAG   = 5'b10000
    } state_t;

    state_t                  state_reg;
    state_t                  state_next;
    logic [bfsp_pkg::CFG_W-1:0] nodes_used_reg;
    logic [NODE_CNT_W-1:0]   n_eff;
    logic [NODE_CNT_W-1:0]   n_last;
    logic                    accept;
    logic                    run_accept;
    logic                    cfg_write;
    logic [bfsp_pkg::APB_ADDR_W-3:0] cfg_word;

    logic [EDGE_CNT_W-1:0]   e_reg;
    logic [EDGE_CNT_W-1:0]   e_next;
    logic [NODE_CNT_W-1:0]   p_reg;
    logic [NODE_CNT_W-1:0]   p_next;
    logic [NODE_CNT_W-1:0]   r_reg;
    logic [NODE_CNT_W-1:0]   r_next;
    logic [1:0]              drain_reg;
    logic [1:0]              drain_next;
    logic                    iss_valid_reg;
    logic                    iss_valid_next;
    logic                    iss_check_reg;
    logic                    iss_check_next;
    logic                    rpt_v_reg;
    logic                    rpt_v_next;
    logic [bfsp_pkg::NODE_W-1:0] rpt_id_reg;
    logic                    rpt_last_reg;
    logic                    rpt_last_next;
    logic                    res_valid_reg;
    logic                    res_valid_next;
    bfsp_pkg::result_t       res_reg;
    bfsp_pkg::result_t       res_next;

    logic [EDGE_CNT_W-1:0]   edge_total;
    logic                    overflow;
    logic [bfsp_pkg::NODE_W-1:0]   es_source;
    logic [bfsp_pkg::NODE_W-1:0]   es_target;
    logic signed [WEIGHT_BITS-1:0] es_weight;
    bfsp_pkg::relax_ctrl_t   relax_ctrl;
    logic signed [DIST_W-1:0] report_dist;
    logic                    report_reached;
    logic                    neg_found;
    logic signed [bfsp_pkg::COST_W-1:0] sat_cost;
    logic                    last_edge;

    assign accept     = start && !busy;
    assign run_accept = accept && (request.kind == bfsp_pkg::KIND_RUN);

    // Configuration register
    assign cfg_word  = paddr[bfsp_pkg::APB_ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (cfg_word == bfsp_pkg::REG_NODES_USED) ?
                       bfsp_pkg::APB_DATA_W'(nodes_used_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nodes_used_reg <= bfsp_pkg::NODES_USED_RST;
        end
        else if (cfg_write && cfg_word == bfsp_pkg::REG_NODES_USED)
        begin
            nodes_used_reg <= pwdata[bfsp_pkg::CFG_W-1:0];
        end
    end

    // Clamp node count to 1..MAX_NODES
    always_comb
    begin
        if (nodes_used_reg == '0)
        begin
            n_eff = NODE_CNT_W'(1);
        end
        else if (int'(nodes_used_reg) > MAX_NODES)
        begin
            n_eff = NODE_CNT_W'(MAX_NODES);
        end
        else
        begin
            n_eff = NODE_CNT_W'(nodes_used_reg);
        end
    end
    assign n_last = NODE_CNT_W'(n_eff - 1'b1);

    bfsp_edge_store #(
        .MAX_EDGES   (MAX_EDGES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .EDGE_IDX_W  (EDGE_IDX_W),
        .EDGE_CNT_W  (EDGE_CNT_W)
    ) u_edge_store (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .request    (request),
        .rd_addr    (e_reg[EDGE_IDX_W-1:0]),
        .rd_source  (es_source),
        .rd_target  (es_target),
        .rd_weight  (es_weight),
        .edge_total (edge_total),
        .overflow   (overflow)
    );

    assign relax_ctrl.init       = run_accept;
    assign relax_ctrl.edge_valid = iss_valid_reg;
    assign relax_ctrl.edge_check = iss_check_reg;
    assign relax_ctrl.report     = (state_reg == ST_REPORT);

    bfsp_relax_unit #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .NODE_IDX_W  (NODE_IDX_W),
        .NODE_CNT_W  (NODE_CNT_W),
        .DIST_W      (DIST_W)
    ) u_relax (
        .clk            (clk),
        .rst_n          (rst_n),
        .ctrl           (relax_ctrl),
        .node_limit     (n_eff),
        .edge_source    (es_source),
        .edge_target    (es_target),
        .edge_weight    (es_weight),
        .report_addr    (NODE_IDX_W'(r_reg)),
        .report_dist    (report_dist),
        .report_reached (report_reached),
        .neg_found      (neg_found)
    );

    // Saturate the distance to the result width
    always_comb
    begin
        if (report_dist > DIST_W'(bfsp_pkg::COST_MAX))
        begin
            sat_cost = bfsp_pkg::COST_W'(bfsp_pkg::COST_MAX);
        end
        else if (report_dist < DIST_W'(bfsp_pkg::COST_MIN))
        begin
            sat_cost = bfsp_pkg::COST_W'(bfsp_pkg::COST_MIN);
        end
        else
        begin
            sat_cost = bfsp_pkg::COST_W'(report_dist);
        end
    end

    assign last_edge = (EDGE_CNT_W'(e_reg + 1'b1) == edge_total);

    // Run sequencer: issue edges, drain, report or flag a negative cycle
    always_comb
    begin
        state_next     = state_reg;
        e_next         = e_reg;
        p_next         = p_reg;
        r_next         = r_reg;
        drain_next     = drain_reg;
        iss_valid_next = 1'b0;
        iss_check_next = 1'b0;
        rpt_v_next     = 1'b0;
        rpt_last_next  = 1'b0;
        res_valid_next = 1'b0;
        res_next       = res_reg;

        // Format a node result from the registered readout
        if (rpt_v_reg)
        begin
            res_valid_next          = 1'b1;
            res_next.node_id        = rpt_id_reg;
            res_next.path_cost      = report_reached ? sat_cost : '0;
            res_next.reachable      = report_reached;
            res_next.negative_cycle = 1'b0;
            res_next.edges_dropped  = overflow;
            res_next.last           = rpt_last_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (run_accept)
                begin
                    e_next     = '0;
                    p_next     = '0;
                    drain_next = '0;
                    state_next = (edge_total == '0) ? ST_DRAIN : ST_RELAX;
                end
            end
            ST_RELAX:
            begin
                iss_valid_next = 1'b1;
                iss_check_next = (p_reg == n_last);
                if (last_edge)
                begin
                    e_next = '0;
                    if (p_reg == n_last)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        p_next = NODE_CNT_W'(p_reg + 1'b1);
                    end
                end
                else
                begin
                    e_next = EDGE_CNT_W'(e_reg + 1'b1);
                end
            end
            ST_DRAIN:
            begin
                drain_next = drain_reg + 1'b1;
                if (drain_reg == DRAIN_LAST)
                begin
                    r_next     = '0;
                    state_next = neg_found ? ST_FLAG : ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                rpt_v_next    = 1'b1;
                rpt_last_next = (r_reg == n_last);
                r_next        = NODE_CNT_W'(r_reg + 1'b1);
                if (r_reg == n_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_FLAG:
            begin
                res_valid_next          = 1'b1;
                res_next.node_id        = '0;
                res_next.path_cost      = '0;
                res_next.reachable      = 1'b0;
                res_next.negative_cycle = 1'b1;
                res_next.edges_dropped  = overflow;
                res_next.last           = 1'b1;
                state_next              = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_valid_reg <= 1'b0;
            rpt_v_reg     <= 1'b0;
            res_valid_reg <= 1'b0;
            e_reg         <= '0;
            p_reg         <= '0;
            r_reg         <= '0;
            drain_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            iss_valid_reg <= iss_valid_next;
            rpt_v_reg     <= rpt_v_next;
            res_valid_reg <= res_valid_next;
            e_reg         <= e_next;
            p_reg         <= p_next;
            r_reg         <= r_next;
            drain_reg     <= drain_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        iss_check_reg <= iss_check_next;
        rpt_id_reg    <= bfsp_pkg::NODE_W'(r_reg);
        rpt_last_reg  <= rpt_last_next;
        res_reg       <= res_next;
    end

    assign busy         = (state_reg != ST_IDLE) || rpt_v_reg;
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

/* hw/rtl/bfsp_checker.sv */
// Port-level checks for the shortest-path core, bound to the top level.
// Depends on bfsp_pkg and bellman_ford_shortest_path_core.
`timescale 1ns / 1ps

module bfsp_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input bfsp_pkg::request_t request,
    input logic               result_valid,
    input bfsp_pkg::result_t  result
);

    // Results only follow a busy cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> $past(busy))
        else $error("result without a run in progress");

    // A run request occupies the core
    assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && request.kind == bfsp_pkg::KIND_RUN) |=> busy)
        else $error("run request did not raise busy");

    // Cycle report is a final and empty result
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result.negative_cycle) |->
        (result.last && !result.reachable && result.node_id == '0 && result.path_cost == '0))
        else $error("malformed negative-cycle result");

    // Unreached nodes report zero cost
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.reachable) |-> (result.path_cost == '0))
        else $error("unreached node with nonzero cost");

endmodule

bind bellman_ford_shortest_path_core bfsp_checker u_bfsp_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .request      (request),
    .result_valid (result_valid),
    .result       (result)
);

/* test/bellman_ford_shortest_path_core_test.sv */
// Self-checking testbench for the Bellman-Ford shortest-path core: directed and random
// edge loads and runs, checked against an in-bench shortest-path predictor.
// Depends on bfsp_pkg and bellman_ford_shortest_path_core.
`timescale 1ns / 1ps

module bellman_ford_shortest_path_core_test;

    localparam int NODE_LIMIT = bfsp_pkg::MAX_NODES_DEF;
    localparam int EDGE_LIMIT = bfsp_pkg::MAX_EDGES_DEF;
    localparam int WEIGHT_W = bfsp_pkg::WEIGHT_BITS_DEF;
    localparam logic [bfsp_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam int IDLE_PERCENT = 11;
    localparam int DRAIN_CYCLES = 24;
    localparam int STALL_LIMIT = 40000;
    localparam int REPORT_LIMIT = 10;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic busy;
    bfsp_pkg::request_t request = '0;
    logic result_valid;
    bfsp_pkg::result_t result;
    logic psel = 1'b0;
    logic penable = 1'b0;
    logic pwrite = 1'b0;
    logic [bfsp_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [bfsp_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [bfsp_pkg::APB_DATA_W-1:0] prdata;
    logic pready;

    // request source and expected node results
    bfsp_pkg::request_t pending_requests[$];
    bfsp_pkg::result_t expected_results[$];
    bit driver_gaps = 1'b1;
    int error_count = 0;
    int stall_cycles = 0;
    bfsp_pkg::result_t want_result;

    // shadow of the edge store, distances and node count
    logic [bfsp_pkg::NODE_W-1:0] edge_src_mem[EDGE_LIMIT];
    logic [bfsp_pkg::NODE_W-1:0] edge_dst_mem[EDGE_LIMIT];
    longint edge_wt_mem[EDGE_LIMIT];
    int stored_edges = 0;
    bit store_overflowed = 1'b0;
    longint dist_mem[NODE_LIMIT];
    bit reached_mem[NODE_LIMIT];
    logic [bfsp_pkg::CFG_W-1:0] nodes_used_shadow = bfsp_pkg::NODES_USED_RST;

    bellman_ford_shortest_path_core DUT (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .request(request),
        .result_valid(result_valid),
        .result(result),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // one sweep over the stored edges; in check mode report any edge that still relaxes
    function automatic bit relax_all_edges(int n, bit check_only);
        int s;
        int t;
        longint cand;
        for (int e = 0; e < stored_edges; e++)
        begin
            s = edge_src_mem[e];
            t = edge_dst_mem[e];
            if (s >= n || t >= n || !reached_mem[s])
                continue;
            cand = dist_mem[s] + edge_wt_mem[e];
            if (!reached_mem[t] || cand < dist_mem[t])
            begin
                if (check_only)
                    return 1'b1;
                dist_mem[t] = cand;
                reached_mem[t] = 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic logic signed [bfsp_pkg::COST_W-1:0] clamp_cost(longint d);
        if (d > bfsp_pkg::COST_MAX)
            d = bfsp_pkg::COST_MAX;
        if (d < bfsp_pkg::COST_MIN)
            d = bfsp_pkg::COST_MIN;
        return d[bfsp_pkg::COST_W-1:0];
    endfunction

    // compute the node results of one run
    function automatic void predict_run();
        int n;
        bfsp_pkg::result_t r;
        n = nodes_used_shadow;
        if (n < 1)
            n = 1;
        if (n > NODE_LIMIT)
            n = NODE_LIMIT;
        for (int i = 0; i < NODE_LIMIT; i++)
        begin
            dist_mem[i] = 0;
            reached_mem[i] = 1'b0;
        end
        reached_mem[0] = 1'b1;
        for (int p = 1; p < n; p++)
            void'(relax_all_edges(n, 1'b0));
        if (relax_all_edges(n, 1'b1))
        begin
            r = '0;
            r.negative_cycle = 1'b1;
            r.edges_dropped = store_overflowed;
            r.last = 1'b1;
            expected_results.insert(expected_results.size(), r);
            return;
        end
        for (int i = 0; i < n; i++)
        begin
            r = '0;
            r.node_id = bfsp_pkg::NODE_W'(i);
            r.path_cost = reached_mem[i] ? clamp_cost(dist_mem[i]) : '0;
            r.reachable = reached_mem[i];
            r.edges_dropped = store_overflowed;
            r.last = (i + 1 == n);
            expected_results.insert(expected_results.size(), r);
        end
    endfunction

    // update the shadow state for one accepted request
    function automatic void predict_request(bfsp_pkg::request_t req);
        longint w;
        case (req.kind)
            bfsp_pkg::KIND_CLEAR:
            begin
                stored_edges = 0;
                store_overflowed = 1'b0;
            end
            bfsp_pkg::KIND_ADD:
            begin
                if (stored_edges >= EDGE_LIMIT)
                    store_overflowed = 1'b1;
                else
                begin
                    w = longint'($signed(req.edge_weight));
                    if (WEIGHT_W < 64)
                        w = (w <<< (64 - WEIGHT_W)) >>> (64 - WEIGHT_W);
                    edge_src_mem[stored_edges] = req.edge_source;
                    edge_dst_mem[stored_edges] = req.edge_target;
                    edge_wt_mem[stored_edges] = w;
                    stored_edges++;
                end
            end
            bfsp_pkg::KIND_RUN:
                predict_run();
            default:
                ;
        endcase
    endfunction

    function automatic string describe_result(bfsp_pkg::result_t r);
        return $sformatf("node %0d cost %0d reach %0b ncyc %0b drop %0b last %0b",
            r.node_id, r.path_cost, r.reachable, r.negative_cycle, r.edges_dropped, r.last);
    endfunction

    function automatic void report_failure(bit has_want, bfsp_pkg::result_t want,
                                           bfsp_pkg::result_t got);
        error_count++;
        if (error_count <= REPORT_LIMIT)
        begin
            if (has_want)
                $display("%0t result differs: expected %s, got %s", $realtime,
                    describe_result(want), describe_result(got));
            else
                $display("%0t result with nothing expected: %s", $realtime,
                    describe_result(got));
        end
    endfunction

    function automatic void queue_request(logic [bfsp_pkg::KIND_W-1:0] kind, int src, int dst,
                                          int weight);
        bfsp_pkg::request_t req;
        req.kind = kind;
        req.edge_source = bfsp_pkg::NODE_W'(src);
        req.edge_target = bfsp_pkg::NODE_W'(dst);
        req.edge_weight = bfsp_pkg::WFIELD_W'(weight);
        pending_requests.insert(pending_requests.size(), req);
    endfunction

    // mostly nodes in use, sometimes any node the field can name
    function automatic int pick_node(int n);
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(0, n - 1);
        return $urandom_range(0, 31);
    endfunction

    function automatic int pick_weight();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 65)
            return $urandom_range(0, 1000);
        if (pick < 80)
            return -int'($urandom_range(1, 60));
        if (pick < 90)
            return ($urandom_range(0, 1) != 0) ? 32767 : -32768;
        return $urandom_range(0, 65535);
    endfunction

    // drive requests: hold while busy, advance on accept, gap at random
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
            request <= '0;
        end
        else if (!start || !busy)
        begin
            if (start)
                predict_request(request);
            if (pending_requests.size() != 0
                && !(driver_gaps && $urandom_range(0, 99) < IDLE_PERCENT))
            begin
                start <= 1'b1;
                request <= pending_requests.pop_front();
            end
            else
                start <= 1'b0;
        end
    end

    // check each result strobe against the oldest expected result
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
        begin
            if (expected_results.size() == 0)
                report_failure(1'b0, '0, result);
            else
            begin
                want_result = expected_results.pop_front();
                if (result.node_id !== want_result.node_id
                    || result.path_cost !== want_result.path_cost
                    || result.reachable !== want_result.reachable
                    || result.negative_cycle !== want_result.negative_cycle
                    || result.edges_dropped !== want_result.edges_dropped
                    || result.last !== want_result.last)
                    report_failure(1'b1, want_result, result);
            end
        end
    end

    // stop the run when nothing moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("bellman_ford_shortest_path_core: mismatch");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    task automatic write_nodes_used(input int value);
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {bfsp_pkg::REG_NODES_USED, 2'b00};
        pwdata <= bfsp_pkg::APB_DATA_W'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        nodes_used_shadow = value[bfsp_pkg::CFG_W-1:0];
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
    endtask

    // wait for every request and result to drain, then let the core settle
    task automatic wait_until_idle();
        while (pending_requests.size() != 0 || start || expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic queue_random_phase(input int n, input int quota);
        int queued;
        int edges;
        logic [bfsp_pkg::KIND_W-1:0] kind;
        queued = 0;
        while (queued < quota)
        begin
            if ($urandom_range(0, 99) < 75)
            begin
                // well-formed graph: clear, a batch of edges, run
                edges = $urandom_range(0, (n < 12) ? n + 4 : 16);
                queue_request(bfsp_pkg::KIND_CLEAR, $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 65535));
                for (int k = 0; k < edges; k++)
                    queue_request(bfsp_pkg::KIND_ADD, pick_node(n), pick_node(n),
                        pick_weight());
                queue_request(bfsp_pkg::KIND_RUN, $urandom_range(0, 31),
                    $urandom_range(0, 31), $urandom_range(0, 65535));
                queued += edges + 2;
            end
            else
            begin
                // noise: any kind with any fields
                kind = bfsp_pkg::KIND_W'($urandom_range(0, 3));
                queue_request(kind, $urandom_range(0, 31), $urandom_range(0, 31),
                    $urandom_range(0, 65535));
                if (kind != KIND_UNUSED)
                    queued++;
            end
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // single node from reset, empty store
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        wait_until_idle();

        // full node range: extreme weights, top node, unreached source, ignored kind
        write_nodes_used(NODE_LIMIT);
        queue_request(bfsp_pkg::KIND_CLEAR, 0, 0, 0);
        queue_request(bfsp_pkg::KIND_ADD, 0, 1, 32767);
        queue_request(bfsp_pkg::KIND_ADD, 1, 2, -32768);
        queue_request(bfsp_pkg::KIND_ADD, 2, 31, 5);
        queue_request(bfsp_pkg::KIND_ADD, 31, 3, -1);
        queue_request(bfsp_pkg::KIND_ADD, 5, 7, 3);
        queue_request(bfsp_pkg::KIND_ADD, 0, 4, 0);
        queue_request(KIND_UNUSED, 31, 31, -1);
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        // close a negative loop through node 1
        queue_request(bfsp_pkg::KIND_ADD, 3, 1, -32768);
        queue_request(bfsp_pkg::KIND_RUN, 31, 31, -1);
        wait_until_idle();

        // zero node count acts as one node
        write_nodes_used(0);
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        wait_until_idle();

        // node count above the limit acts as the limit
        write_nodes_used(63);
        queue_request(bfsp_pkg::KIND_CLEAR, 0, 0, 0);
        queue_request(bfsp_pkg::KIND_ADD, 0, 1, -5);
        queue_request(bfsp_pkg::KIND_ADD, 1, 2, -7);
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        wait_until_idle();

        // edges naming nodes outside the count are skipped
        write_nodes_used(4);
        queue_request(bfsp_pkg::KIND_CLEAR, 0, 0, 0);
        queue_request(bfsp_pkg::KIND_ADD, 0, 20, 1);
        queue_request(bfsp_pkg::KIND_ADD, 20, 1, 1);
        queue_request(bfsp_pkg::KIND_ADD, 0, 3, -4);
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        wait_until_idle();

        // fill the store past capacity, then clear the drop flag
        write_nodes_used(2);
        queue_request(bfsp_pkg::KIND_CLEAR, 0, 0, 0);
        for (int k = 0; k < EDGE_LIMIT + 2; k++)
            queue_request(bfsp_pkg::KIND_ADD, 0, 1, $urandom_range(0, 500));
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        queue_request(bfsp_pkg::KIND_CLEAR, 0, 0, 0);
        queue_request(bfsp_pkg::KIND_RUN, 0, 0, 0);
        wait_until_idle();

        // random graphs over several node counts; one phase without gaps
        write_nodes_used($urandom_range(2, 8));
        queue_random_phase(nodes_used_shadow, 20);
        wait_until_idle();
        driver_gaps = 1'b0;
        write_nodes_used(NODE_LIMIT);
        queue_random_phase(NODE_LIMIT, 20);
        wait_until_idle();
        driver_gaps = 1'b1;
        write_nodes_used($urandom_range(9, 31));
        queue_random_phase(nodes_used_shadow, 20);
        wait_until_idle();
        write_nodes_used(1);
        queue_random_phase(1, 15);
        wait_until_idle();
        write_nodes_used($urandom_range(2, 16));
        queue_random_phase(nodes_used_shadow, 25);
        wait_until_idle();

        if (error_count == 0 && expected_results.size() == 0)
            $display("bellman_ford_shortest_path_core: match");
        else
            $display("bellman_ford_shortest_path_core: mismatch");
        $finish;
    end

endmodule
